// ===== design/salru_pkg.sv =====
// Shared constants, codes and types of the set-associative LRU cache lookup.
package salru_pkg;

  // Built geometry
  localparam int MAX_SETS   = 256;
  localparam int MAX_WAYS   = 8;
  localparam int ADDR_WIDTH = 64;

  localparam int SET_W    = $clog2(MAX_SETS);
  localparam int WAY_W    = $clog2(MAX_WAYS);
  localparam int WAYCNT_W = $clog2(MAX_WAYS + 1);
  // At least one set bit and one block bit sit below the tag
  localparam int TAG_W    = ADDR_WIDTH - 2;
  // A valid line is never older than the number of valid lines in its set
  localparam int AGE_W    = WAY_W;
  localparam int CNT_W    = 32;

  // Configuration register widths and limits
  localparam int SETB_W         = 4;
  localparam int BLKB_W         = 6;
  localparam int WAYS_W         = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 6;
  localparam int MAX_BLOCK_BITS = 32;
  localparam int SHIFT_W        = 7;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  localparam logic [SETB_W-1:0] RST_SET_BITS   = 4'd4;
  localparam logic [BLKB_W-1:0] RST_BLOCK_BITS = 6'd4;
  localparam logic [WAYS_W-1:0] RST_WAYS       = 4'd1;

  // Access kinds
  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_STORE  = 2'd1;
  localparam logic [1:0] MODE_MODIFY = 2'd2;
  localparam logic [1:0] MODE_NONE   = 2'd3;

  // Lookup outcomes
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [AGE_W-1:0] age;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // take the new item's set and tag, read its row
    logic reread;   // read the held set's row again
    logic access;   // look up, write the row back, publish a result
    logic last;     // this access is the final one of its item
  } ctrl_cmd_t;

endpackage

// ===== design/salru_ctrl.sv =====
// Sequencer: walks each item through row read and lookup/write-back.
module salru_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [1:0]            mode,
  output logic                  busy,
  output salru_pkg::ctrl_cmd_t  cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_ACC    = 2'd1;
  localparam logic [1:0] ST_REREAD = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       pend;
  logic       pend_next;

  // Next state and commands
  always_comb begin
    state_next = state;
    pend_next  = pend;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          if (mode != salru_pkg::MODE_NONE) begin
            state_next = ST_ACC;
            pend_next  = (mode == salru_pkg::MODE_MODIFY);
          end
        end
      end
      ST_ACC: begin
        cmd.access = 1'b1;
        cmd.last   = !pend;
        if (pend) begin
          state_next = ST_REREAD;
          pend_next  = 1'b0;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_REREAD: begin
        cmd.reread = 1'b1;
        state_next = ST_ACC;
      end
      default: begin
        state_next = ST_IDLE;
        pend_next  = 1'b0;
      end
    endcase
  end

  // Advance the sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== design/salru_datapath.sv =====
// Datapath: configuration, tag memory, lookup, LRU ages, totals and result registers.
module salru_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [salru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [salru_pkg::ADDR_WIDTH-1:0]     address,
  input  salru_pkg::ctrl_cmd_t                 cmd,
  output logic                                 strobe,
  output logic [1:0]                           outcome,
  output logic [2:0]                           way_used,
  output logic [salru_pkg::CNT_W-1:0]          hit_total,
  output logic [salru_pkg::CNT_W-1:0]          miss_total,
  output logic [salru_pkg::CNT_W-1:0]          evict_total,
  output logic                                 last_of_item
);

  logic [salru_pkg::SETB_W-1:0]   set_bits;
  logic [salru_pkg::BLKB_W-1:0]   block_bits;
  logic [salru_pkg::WAYS_W-1:0]   ways_in_use;
  logic [salru_pkg::SETB_W-1:0]   set_c;
  logic [salru_pkg::BLKB_W-1:0]   block_c;
  logic [salru_pkg::WAYCNT_W-1:0] ways_c;
  logic [salru_pkg::SHIFT_W-1:0]  tag_shift;
  logic [salru_pkg::SET_W-1:0]    set_mask;
  logic [salru_pkg::SET_W-1:0]    set_in;
  logic [salru_pkg::TAG_W-1:0]    tag_in;
  logic [salru_pkg::SET_W-1:0]    set_idx;
  logic [salru_pkg::TAG_W-1:0]    tag;
  logic [salru_pkg::SET_W-1:0]    rd_addr;
  logic                           rd_en;

  salru_pkg::row_t                mem [salru_pkg::MAX_SETS];
  logic [salru_pkg::MAX_SETS-1:0] row_seen;
  salru_pkg::row_t                row_q;
  logic                           seen_q;
  salru_pkg::row_t                row_new;

  logic [salru_pkg::MAX_WAYS-1:0] in_use;
  logic [salru_pkg::MAX_WAYS-1:0] line_v;
  logic [salru_pkg::MAX_WAYS-1:0] act;
  logic [salru_pkg::MAX_WAYS-1:0] match;
  logic                           hit_found;
  logic [salru_pkg::WAY_W-1:0]    hit_way;
  logic                           empty_found;
  logic [salru_pkg::WAY_W-1:0]    empty_way;
  logic                           old_found;
  logic [salru_pkg::WAY_W-1:0]    old_way;
  logic [salru_pkg::AGE_W-1:0]    old_age;
  logic [salru_pkg::WAY_W-1:0]    target;
  logic [salru_pkg::AGE_W-1:0]    limit;
  logic [1:0]                     outcome_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= salru_pkg::RST_SET_BITS;
      block_bits  <= salru_pkg::RST_BLOCK_BITS;
      ways_in_use <= salru_pkg::RST_WAYS;
    end else if (cfg_we) begin
      case (cfg_index)
        salru_pkg::CFG_SET_BITS:   set_bits    <= cfg_data[salru_pkg::SETB_W-1:0];
        salru_pkg::CFG_BLOCK_BITS: block_bits  <= cfg_data[salru_pkg::BLKB_W-1:0];
        salru_pkg::CFG_WAYS:       ways_in_use <= cfg_data[salru_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the configuration into the built geometry
  always_comb begin
    if (set_bits == '0) begin
      set_c = salru_pkg::SETB_W'(1);
    end else if (set_bits > salru_pkg::SETB_W'(salru_pkg::SET_W)) begin
      set_c = salru_pkg::SETB_W'(salru_pkg::SET_W);
    end else begin
      set_c = set_bits;
    end
    if (block_bits == '0) begin
      block_c = salru_pkg::BLKB_W'(1);
    end else if (block_bits > salru_pkg::BLKB_W'(salru_pkg::MAX_BLOCK_BITS)) begin
      block_c = salru_pkg::BLKB_W'(salru_pkg::MAX_BLOCK_BITS);
    end else begin
      block_c = block_bits;
    end
    if (ways_in_use == '0) begin
      ways_c = salru_pkg::WAYCNT_W'(1);
    end else if (ways_in_use > salru_pkg::WAYS_W'(salru_pkg::MAX_WAYS)) begin
      ways_c = salru_pkg::WAYCNT_W'(salru_pkg::MAX_WAYS);
    end else begin
      ways_c = salru_pkg::WAYCNT_W'(ways_in_use);
    end
  end

  // Split the incoming address into set index and tag
  assign tag_shift = salru_pkg::SHIFT_W'(set_c) + salru_pkg::SHIFT_W'(block_c);
  assign set_mask  = ~({salru_pkg::SET_W{1'b1}} << set_c);
  assign set_in    = salru_pkg::SET_W'(address >> block_c) & set_mask;
  assign tag_in    = salru_pkg::TAG_W'(address >> tag_shift);

  // Hold the set and tag of the item in flight
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      set_idx <= set_in;
      tag     <= tag_in;
    end
  end

  assign rd_addr = cmd.capture ? set_in : set_idx;
  assign rd_en   = cmd.capture | cmd.reread;

  // Tag memory: one row per set, read registered, written back after lookup
  always_ff @(posedge clk) begin
    if (cmd.access) begin
      mem[set_idx] <= row_new;
    end
    if (rd_en) begin
      row_q  <= mem[rd_addr];
      seen_q <= row_seen[rd_addr];
    end
  end

  // Mark rows that hold written lines; an unmarked row reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      row_seen <= '0;
    end else if (cmd.access) begin
      row_seen[set_idx] <= 1'b1;
    end
  end

  // Search the ways in use for a hit, an empty way and the oldest way
  always_comb begin
    hit_found   = 1'b0;
    hit_way     = '0;
    empty_found = 1'b0;
    empty_way   = '0;
    old_found   = 1'b0;
    old_way     = '0;
    old_age     = '0;
    for (int w = 0; w < salru_pkg::MAX_WAYS; w++) begin
      in_use[w] = (salru_pkg::WAYCNT_W'(w) < ways_c);
      line_v[w] = seen_q & row_q[w].valid;
      act[w]    = line_v[w] & in_use[w];
      match[w]  = act[w] & (row_q[w].tag == tag);
      if (match[w] && !hit_found) begin
        hit_found = 1'b1;
        hit_way   = salru_pkg::WAY_W'(w);
      end
      if (in_use[w] && !line_v[w] && !empty_found) begin
        empty_found = 1'b1;
        empty_way   = salru_pkg::WAY_W'(w);
      end
      if (act[w] && (!old_found || row_q[w].age > old_age)) begin
        old_found = 1'b1;
        old_way   = salru_pkg::WAY_W'(w);
        old_age   = row_q[w].age;
      end
    end
  end

  // Pick the target way and the outcome
  always_comb begin
    limit = row_q[hit_way].age;
    if (hit_found) begin
      target       = hit_way;
      outcome_next = salru_pkg::OUT_HIT;
    end else if (empty_found) begin
      target       = empty_way;
      outcome_next = salru_pkg::OUT_FILL;
    end else begin
      target       = old_way;
      outcome_next = salru_pkg::OUT_EVICT;
    end
  end

  // Build the written-back row: age the younger lines, install the target
  always_comb begin
    for (int w = 0; w < salru_pkg::MAX_WAYS; w++) begin
      row_new[w]       = row_q[w];
      row_new[w].valid = line_v[w];
      if (salru_pkg::WAY_W'(w) == target) begin
        row_new[w].valid = 1'b1;
        row_new[w].tag   = tag;
        row_new[w].age   = '0;
      end else if (act[w] && (!hit_found || row_q[w].age < limit) &&
                   row_q[w].age != '1) begin
        row_new[w].age = row_q[w].age + salru_pkg::AGE_W'(1);
      end
    end
  end

  // Running totals, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total   <= '0;
      miss_total  <= '0;
      evict_total <= '0;
    end else if (cmd.access) begin
      if (hit_found) begin
        if (hit_total != '1) begin
          hit_total <= hit_total + salru_pkg::CNT_W'(1);
        end
      end else begin
        if (miss_total != '1) begin
          miss_total <= miss_total + salru_pkg::CNT_W'(1);
        end
        if (!empty_found && evict_total != '1) begin
          evict_total <= evict_total + salru_pkg::CNT_W'(1);
        end
      end
    end
  end

  // Result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.access;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.access) begin
      outcome      <= outcome_next;
      way_used     <= 3'(target);
      last_of_item <= cmd.last;
    end
  end

endmodule

// ===== design/set_assoc_cache_lru_lookup.sv =====
// Top level of the set-associative cache tag lookup with LRU replacement.
// An item (address, mode) is taken when start is high and busy is low. A load
// or a store makes one cache access, a modify makes two, and mode 3 makes none
// and is done in the cycle it is taken. Each access first reads the set's row
// of tags, valid bits and ages from the single-port tag memory, then looks it
// up and writes the row back. A new item is taken only after the last access
// of the previous one. Each result appears on the result ports for
// exactly one cycle, marked by strobe, in the cycle after its write-back; it
// must be taken then, as the block does not wait. Totals are the values after
// that access. Rows never written since reset read as empty through a
// per-set flag, so no clearing pass follows reset. Configure only while idle.
module set_assoc_cache_lru_lookup (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [salru_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [salru_pkg::ADDR_WIDTH-1:0]     address,
  input  logic [1:0]                           mode,
  output logic                                 strobe,
  output logic [1:0]                           outcome,
  output logic [2:0]                           way_used,
  output logic [salru_pkg::CNT_W-1:0]          hit_total,
  output logic [salru_pkg::CNT_W-1:0]          miss_total,
  output logic [salru_pkg::CNT_W-1:0]          evict_total,
  output logic                                 last_of_item
);

  salru_pkg::ctrl_cmd_t cmd;

  // Sequencer
  salru_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Lookup datapath
  salru_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .address      (address),
    .cmd          (cmd),
    .strobe       (strobe),
    .outcome      (outcome),
    .way_used     (way_used),
    .hit_total    (hit_total),
    .miss_total   (miss_total),
    .evict_total  (evict_total),
    .last_of_item (last_of_item)
  );

endmodule

// ===== design/salru_checker.sv =====
// Port-level checks of the cache lookup, bound to the top level.
module salru_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        busy,
  input logic                        strobe,
  input logic [1:0]                  outcome,
  input logic                        last_of_item,
  input logic [salru_pkg::CNT_W-1:0] hit_total,
  input logic [salru_pkg::CNT_W-1:0] miss_total,
  input logic [salru_pkg::CNT_W-1:0] evict_total
);

  // A result only follows work the block was busy with
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(busy))
    else $error("result transfer without preceding busy cycle");

  // Totals move only with a result transfer
  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    (!strobe && !$past(rst)) |->
      ($stable(hit_total) && $stable(miss_total) && $stable(evict_total)))
    else $error("totals changed without a result transfer");

  // A hit bumps the hit total unless saturated
  a_hit_counts: assert property (@(posedge clk) disable iff (rst)
    (strobe && outcome == salru_pkg::OUT_HIT) |->
      (hit_total != $past(hit_total) || hit_total == '1))
    else $error("hit result without hit total advance");

  // An eviction bumps the eviction total unless saturated
  a_evict_counts: assert property (@(posedge clk) disable iff (rst)
    (strobe && outcome == salru_pkg::OUT_EVICT) |->
      (evict_total != $past(evict_total) || evict_total == '1))
    else $error("eviction result without eviction total advance");

  // The first access of a modify is followed, after a gap for the row reread, by its second
  a_modify_pair: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_of_item) |=> (!strobe ##1 strobe))
    else $error("second access of a modify missing");

endmodule

bind set_assoc_cache_lru_lookup salru_checker u_salru_checker (
  .clk          (clk),
  .rst          (rst),
  .busy         (busy),
  .strobe       (strobe),
  .outcome      (outcome),
  .last_of_item (last_of_item),
  .hit_total    (hit_total),
  .miss_total   (miss_total),
  .evict_total  (evict_total)
);

// ===== tb/tb_set_assoc_cache_lru_lookup.sv =====
// Self-checking testbench for the set-associative LRU cache tag lookup.
module tb_set_assoc_cache_lru_lookup;
  timeunit 1ns;
  timeprecision 1ps;

  import salru_pkg::*;

  localparam int LINES      = MAX_SETS * MAX_WAYS;
  localparam int RAND_ITEMS = 1150;
  localparam int CYCLE_CAP  = 300000;
  localparam int SETTLE     = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic [ADDR_WIDTH-1:0] addr;
    logic [1:0]            mode;
  } cache_item_t;

  typedef struct {
    logic [1:0]       outcome;
    logic [2:0]       way;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evicts;
    logic             last;
  } lookup_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ADDR_WIDTH-1:0] address = '0;
  logic [1:0]            mode = MODE_LOAD;
  logic                  strobe;
  logic [1:0]            outcome;
  logic [2:0]            way_used;
  logic [CNT_W-1:0]      hit_total;
  logic [CNT_W-1:0]      miss_total;
  logic [CNT_W-1:0]      evict_total;
  logic                  last_of_item;

  set_assoc_cache_lru_lookup dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .start        (start),
    .busy         (busy),
    .address      (address),
    .mode         (mode),
    .strobe       (strobe),
    .outcome      (outcome),
    .way_used     (way_used),
    .hit_total    (hit_total),
    .miss_total   (miss_total),
    .evict_total  (evict_total),
    .last_of_item (last_of_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Shadow cache: tags, valid bits, per-line ages, totals and registers
  bit               shadow_valid [LINES];
  logic [63:0]      shadow_tag   [LINES];
  int               shadow_age   [LINES];
  logic [CNT_W-1:0] hits_n, misses_n, evicts_n;
  logic [3:0]       set_bits_r;
  logic [5:0]       block_bits_r;
  logic [3:0]       ways_r;

  cache_item_t    pending_items[$];
  lookup_result_t expected_results[$];
  logic [63:0]    tag_pool[$];
  int             set_base;
  bit             gaps_on = 1'b1;
  int             errors = 0;
  int             cycles = 0;

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Look up one access in the shadow cache and update it as the block would
  function automatic lookup_result_t cache_access(logic [63:0] addr, bit last_one);
    int s, b, n, base, hit, empty, oldest, lim, target, i;
    logic [63:0] tag;
    lookup_result_t r;
    s = clamp(set_bits_r, 1, SET_W);
    b = clamp(block_bits_r, 1, MAX_BLOCK_BITS);
    n = clamp(ways_r, 1, MAX_WAYS);
    base = int'((addr >> b) & ((64'd1 << s) - 1)) * MAX_WAYS;
    tag = addr >> (s + b);
    hit = -1;
    empty = -1;
    oldest = -1;
    for (int w = 0; w < n; w++) begin
      i = base + w;
      if (shadow_valid[i]) begin
        if (hit < 0 && shadow_tag[i] == tag) hit = w;
        if (oldest < 0 || shadow_age[i] > shadow_age[base + oldest]) oldest = w;
      end else if (empty < 0) begin
        empty = w;
      end
    end
    if (hit >= 0) begin
      r.outcome = OUT_HIT;
      target = hit;
      lim = shadow_age[base + hit];
      hits_n = bump(hits_n);
    end else begin
      misses_n = bump(misses_n);
      lim = 256;
      if (empty >= 0) begin
        r.outcome = OUT_FILL;
        target = empty;
      end else begin
        r.outcome = OUT_EVICT;
        target = oldest;
        evicts_n = bump(evicts_n);
      end
    end
    // Age the younger valid ways, then make the accessed way the newest
    for (int w = 0; w < n; w++) begin
      i = base + w;
      if (w != target && shadow_valid[i] && shadow_age[i] < lim && shadow_age[i] < 255)
        shadow_age[i]++;
    end
    shadow_valid[base + target] = 1'b1;
    shadow_tag[base + target] = tag;
    shadow_age[base + target] = 0;
    r.way = target[2:0];
    r.hits = hits_n;
    r.misses = misses_n;
    r.evicts = evicts_n;
    r.last = last_one;
    return r;
  endfunction

  function automatic void predict_item(logic [63:0] addr, logic [1:0] kind);
    case (kind)
      MODE_NONE: ;
      MODE_MODIFY: begin
        expected_results.push_back(cache_access(addr, 1'b0));
        expected_results.push_back(cache_access(addr, 1'b1));
      end
      default: expected_results.push_back(cache_access(addr, 1'b1));
    endcase
  endfunction

  // Driver: retire the accepted transfer, then present the next queued item
  always @(posedge clk) begin : drive_items
    cache_item_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) predict_item(address, mode);
      if (!start || !busy) begin
        if (pending_items.size() != 0 && !(gaps_on && $urandom_range(0, 99) < 15)) begin
          nxt = pending_items.pop_front();
          start <= 1'b1;
          address <= nxt.addr;
          mode <= nxt.mode;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor: compare each strobed result with the oldest expectation
  always @(posedge clk) begin : watch_results
    lookup_result_t want;
    if (!rst && strobe) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual outcome %0d way %0d",
                 $time, outcome, way_used);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("outcome", want.outcome, outcome);
        check_field("way_used", want.way, way_used);
        check_field("hit_total", want.hits, hit_total);
        check_field("miss_total", want.misses, miss_total);
        check_field("evict_total", want.evicts, evict_total);
        check_field("last_of_item", want.last, last_of_item);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_CAP) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_item(input logic [63:0] addr, input logic [1:0] kind);
    cache_item_t it;
    it.addr = addr;
    it.mode = kind;
    pending_items.push_back(it);
  endtask

  // Hold until every item is taken and every result is back, then settle
  task automatic wait_idle();
    while (pending_items.size() != 0 || start || busy || expected_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_SET_BITS:   set_bits_r = val[3:0];
      CFG_BLOCK_BITS: block_bits_r = val;
      CFG_WAYS:       ways_r = val[3:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(input logic [5:0] sv, input logic [5:0] bv, input logic [5:0] wv);
    wait_idle();
    write_reg(CFG_SET_BITS, sv);
    write_reg(CFG_BLOCK_BITS, bv);
    write_reg(CFG_WAYS, wv);
  endtask

  // Address aimed at a couple of sets and a small tag pool, with some noise
  function automatic logic [63:0] phase_address(int es, int eb);
    logic [63:0] tg, st, off;
    if ($urandom_range(0, 99) < 15) return {$urandom, $urandom};
    tg = tag_pool[$urandom_range(0, tag_pool.size() - 1)];
    st = 64'(set_base + $urandom_range(0, 1)) & ((64'd1 << es) - 1);
    off = {$urandom, $urandom} & ((64'd1 << eb) - 1);
    return (tg << (es + eb)) | (st << eb) | off;
  endfunction

  function automatic logic [5:0] pick_reg(int lo, int hi);
    return ($urandom_range(0, 99) < 25) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(lo, hi));
  endfunction

  initial begin : stimulus
    int issued, phase, es, eb, ew, count;
    logic [5:0] sv, bv, wv;
    logic [1:0] kind;
    for (int i = 0; i < LINES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_tag[i] = '0;
      shadow_age[i] = 0;
    end
    hits_n = '0;
    misses_n = '0;
    evicts_n = '0;
    set_bits_r = RST_SET_BITS;
    block_bits_r = RST_BLOCK_BITS;
    ways_r = RST_WAYS;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Reset geometry: fill, hit, modify, evict, unused mode
    push_item(64'h0, MODE_LOAD);
    push_item(64'h0, MODE_STORE);
    push_item('1, MODE_MODIFY);
    push_item(64'h100, MODE_LOAD);
    push_item('1, MODE_NONE);
    // Second way fills, then a single way duplicates a tag across the set
    configure(6'd4, 6'd4, 6'd2);
    push_item(64'h0, MODE_LOAD);
    push_item(64'h100, MODE_STORE);
    configure(6'd4, 6'd4, 6'd1);
    push_item(64'h0, MODE_LOAD);
    // Several matching ways: the lowest one must hit
    configure(6'd4, 6'd4, 6'd2);
    push_item(64'h0, MODE_MODIFY);
    push_item(64'h200, MODE_LOAD);
    // Registers below range saturate up
    configure(6'd0, 6'd0, 6'd0);
    push_item(64'h5, MODE_LOAD);
    push_item(64'h7, MODE_MODIFY);
    // Registers above range saturate down; spare index is ignored
    configure(6'd15, 6'd63, 6'd15);
    write_reg(CFG_SPARE, 6'h2a);
    push_item('1, MODE_LOAD);
    push_item(64'h8000_0000_0000_0000, MODE_STORE);
    push_item(64'h0, MODE_MODIFY);
    // Smallest geometry, all ways: overfill set zero to force eviction
    configure(6'd1, 6'd1, 6'd8);
    for (int k = 1; k <= 9; k++) push_item(64'(k) << 2, MODE_LOAD);

    // Random phases, each with its own geometry and address pool
    issued = 0;
    phase = 0;
    while (issued < RAND_ITEMS) begin
      sv = pick_reg(1, 4);
      bv = pick_reg(1, 8);
      wv = pick_reg(1, MAX_WAYS);
      configure(sv, bv, wv);
      gaps_on = !(phase >= 4 && phase < 8);
      es = clamp(sv[3:0], 1, SET_W);
      eb = clamp(bv, 1, MAX_BLOCK_BITS);
      ew = clamp(wv[3:0], 1, MAX_WAYS);
      tag_pool.delete();
      repeat (ew + 2)
        tag_pool.push_back(($urandom_range(0, 1) != 0) ? 64'($urandom_range(0, 7))
                                                       : {$urandom, $urandom});
      set_base = $urandom_range(0, MAX_SETS - 1);
      count = $urandom_range(30, 80);
      for (int k = 0; k < count; k++) begin
        kind = ($urandom_range(0, 19) == 0) ? MODE_NONE : 2'($urandom_range(0, 2));
        push_item(phase_address(es, eb), kind);
        if (kind != MODE_NONE) issued++;
      end
      phase++;
    end

    wait_idle();
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
